// ----- src/cc20_pkg.sv -----
// Shared types, constants and helper functions for the ChaCha20 stream XOR block.
`default_nettype none

package cc20_pkg;

    // Default number of double rounds per keystream block.
    localparam int DOUBLE_ROUNDS_DEF = 10;

    // Expansion constant words ("expand 32-byte k").
    localparam logic [31:0] SIGMA_0 = 32'h61707865;
    localparam logic [31:0] SIGMA_1 = 32'h3320646e;
    localparam logic [31:0] SIGMA_2 = 32'h79622d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b206574;

    localparam logic [3:0] MAX_BYTES = 4'd8;

    typedef logic [31:0] t_word;
    typedef logic [15:0][31:0] t_words;
    typedef logic [7:0][63:0] t_ks;

    // Four words that one quarter-round lane works on.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_quad;

    // Input and output transaction payloads.
    typedef struct packed {
        logic        first;
        logic [63:0] data_in;
        logic [3:0]  byte_count;
    } t_in_item;

    typedef struct packed {
        logic [63:0] data_out;
        logic [3:0]  valid_bytes;
    } t_out_item;

    // Block request from the stream controller to the core, and core status back.
    typedef struct packed {
        logic  start;
        t_word counter;
    } t_core_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_EMIT
    } t_top_state;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_FF
    } t_core_state;

    typedef enum logic [2:0] {
        CFG_KEY_0,
        CFG_KEY_1,
        CFG_KEY_2,
        CFG_KEY_3,
        CFG_NONCE_LOW,
        CFG_NONCE_HIGH,
        CFG_START_COUNTER
    } t_cfg_idx;

    // Rotate a word left by a constant amount.
    function automatic t_word rotl(t_word x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // Clamp a byte count to eight.
    function automatic logic [3:0] sat_count(logic [3:0] c);
        return (c > MAX_BYTES) ? MAX_BYTES : c;
    endfunction

    // Keep the low bytes that a count marks as valid.
    function automatic logic [63:0] byte_mask(logic [3:0] c);
        logic [63:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b*8 +: 8] = (4'(b) < c) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // Initial state of a block from key, counter and nonce.
    function automatic t_words make_init(logic [255:0] key, logic [95:0] nonce,
                                         t_word counter);
        t_words w;
        w[0] = SIGMA_0;
        w[1] = SIGMA_1;
        w[2] = SIGMA_2;
        w[3] = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            w[4 + i] = key[i*32 +: 32];
        end
        w[12] = counter;
        for (int i = 0; i < 3; i++) begin
            w[13 + i] = nonce[i*32 +: 32];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- src/cc20_qr.sv -----
// One quarter-round lane of the ChaCha20 permutation.
`default_nettype none

module cc20_qr
    import cc20_pkg::*;
(
    input  t_quad i_q,
    output t_quad o_q
);

    t_word a1, b1, c1, d1, a2, b2, c2, d2;

    // Add, XOR and rotate steps of one quarter round.
    assign a1 = i_q.a + i_q.b;
    assign d1 = rotl(i_q.d ^ a1, 16);
    assign c1 = i_q.c + d1;
    assign b1 = rotl(i_q.b ^ c1, 12);
    assign a2 = a1 + b1;
    assign d2 = rotl(d1 ^ a2, 8);
    assign c2 = c1 + d2;
    assign b2 = rotl(b1 ^ c2, 7);

    assign o_q = '{a: a2, b: b2, c: c2, d: d2};

endmodule

`default_nettype wire

// ----- src/cc20_core.sv -----
// Keystream block generator: four quarter-round lanes, round sequencer, feed-forward stage.
`default_nettype none

module cc20_core
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_core_req    i_req,
    input  logic [255:0] i_key,
    input  logic [95:0]  i_nonce,
    output t_core_stat   o_stat,
    output t_ks          o_ks
);

    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int CW = $clog2(HALF_ROUNDS);

    t_core_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    t_words r_w, n_w;
    t_word r_ctr;
    t_ks r_ks;
    t_words init_w;
    t_quad lane_in [4];
    t_quad lane_out [4];
    logic diag;

    assign init_w = make_init(i_key, i_nonce, r_ctr);
    assign diag = r_cnt[0];

    // Route words to the lanes: column round on even steps, diagonal round on odd.
    always_comb begin
        if (diag) begin
            lane_in[0] = '{a: r_w[0], b: r_w[5], c: r_w[10], d: r_w[15]};
            lane_in[1] = '{a: r_w[1], b: r_w[6], c: r_w[11], d: r_w[12]};
            lane_in[2] = '{a: r_w[2], b: r_w[7], c: r_w[8],  d: r_w[13]};
            lane_in[3] = '{a: r_w[3], b: r_w[4], c: r_w[9],  d: r_w[14]};
        end else begin
            lane_in[0] = '{a: r_w[0], b: r_w[4], c: r_w[8],  d: r_w[12]};
            lane_in[1] = '{a: r_w[1], b: r_w[5], c: r_w[9],  d: r_w[13]};
            lane_in[2] = '{a: r_w[2], b: r_w[6], c: r_w[10], d: r_w[14]};
            lane_in[3] = '{a: r_w[3], b: r_w[7], c: r_w[11], d: r_w[15]};
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        cc20_qr u_qr (
            .i_q(lane_in[l]),
            .o_q(lane_out[l])
        );
    end

    // Put the lane results back where they came from.
    always_comb begin
        n_w = r_w;
        if (diag) begin
            {n_w[0], n_w[5], n_w[10], n_w[15]} = lane_out[0];
            {n_w[1], n_w[6], n_w[11], n_w[12]} = lane_out[1];
            {n_w[2], n_w[7], n_w[8],  n_w[13]} = lane_out[2];
            {n_w[3], n_w[4], n_w[9],  n_w[14]} = lane_out[3];
        end else begin
            {n_w[0], n_w[4], n_w[8],  n_w[12]} = lane_out[0];
            {n_w[1], n_w[5], n_w[9],  n_w[13]} = lane_out[1];
            {n_w[2], n_w[6], n_w[10], n_w[14]} = lane_out[2];
            {n_w[3], n_w[7], n_w[11], n_w[15]} = lane_out[3];
        end
    end

    // Sequencer next state and status.
    always_comb begin
        n_state = r_state;
        o_stat.busy = (r_state != CORE_IDLE);
        o_stat.done = 1'b0;
        unique case (r_state)
            CORE_IDLE: begin
                if (i_req.start) n_state = CORE_ROUND;
            end
            CORE_ROUND: begin
                if (r_cnt == CW'(HALF_ROUNDS - 1)) n_state = CORE_FF;
            end
            CORE_FF: begin
                o_stat.done = 1'b1;
                n_state = CORE_IDLE;
            end
            default: n_state = CORE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working state, round count and the merged keystream block.
    always_ff @(posedge i_clk) begin
        if (r_state == CORE_IDLE && i_req.start) begin
            r_ctr <= i_req.counter;
            r_w   <= make_init(i_key, i_nonce, i_req.counter);
            r_cnt <= '0;
        end else if (r_state == CORE_ROUND) begin
            r_w   <= n_w;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == CORE_FF) begin
            for (int j = 0; j < 8; j++) begin
                r_ks[j] <= {r_w[2*j+1] + init_w[2*j+1], r_w[2*j] + init_w[2*j]};
            end
        end
    end

    assign o_ks = r_ks;

endmodule

`default_nettype wire

// ----- src/chacha20_stream_xor_top.sv -----
// ChaCha20 stream XOR block: configuration registers, stream control and output register.
//
// Usage: items of up to eight stream bytes enter on the input channel (valid/ready) and
// one result per item leaves on the output channel (valid/ready). Keys, nonce and the
// start counter are written through the plain configuration write port while idle.
// An item with first set restarts the stream at the start counter.
// Block flow: the first item of each 64-byte keystream block waits for the core, which
// runs one column or diagonal round per cycle on four quarter-round lanes through
// 2*DOUBLE_ROUNDS round steps, then a feed-forward step and the output register; the
// input reopens when that result is loaded. The other seven items of a block go straight
// out, one per cycle while the output register is free. The round loop of the core sets
// the block rate.
// Reset clears the stream position, block counter, configuration registers and the
// output valid flag; no keystream block is held afterward.
// When the receiver stalls, one result waits in the output register and one more item
// can be accepted and held; input ready then stays low until the output drains.
`default_nettype none

module chacha20_stream_xor_top
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Configuration registers.
    logic [63:0] r_key [4];
    logic [63:0] r_nonce_low;
    logic [31:0] r_nonce_high;
    logic [31:0] r_start;

    // Stream state.
    t_top_state r_state, n_state;
    t_word r_counter;
    logic [2:0] r_slot;
    logic r_blk_valid;

    // Held item and output register.
    t_in_item r_item;
    logic [2:0] r_item_slot;
    logic r_out_valid;
    t_out_item r_out, n_out;

    t_core_req core_req;
    t_core_stat core_stat;
    t_ks ks;

    logic in_fire, out_free, need_block, load_out;
    logic [2:0] eff_slot, sel_slot;
    logic eff_valid;
    t_word eff_counter;
    t_in_item sel_item;
    logic [3:0] sel_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
            r_start      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_0:         r_key[0]     <= i_cfg_data;
                CFG_KEY_1:         r_key[1]     <= i_cfg_data;
                CFG_KEY_2:         r_key[2]     <= i_cfg_data;
                CFG_KEY_3:         r_key[3]     <= i_cfg_data;
                CFG_NONCE_LOW:     r_nonce_low  <= i_cfg_data;
                CFG_NONCE_HIGH:    r_nonce_high <= i_cfg_data[31:0];
                CFG_START_COUNTER: r_start      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Stream position after an optional restart.
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign eff_slot    = i_in_item.first ? 3'd0 : r_slot;
    assign eff_valid   = i_in_item.first ? 1'b0 : r_blk_valid;
    assign eff_counter = i_in_item.first ? r_start : r_counter;
    assign need_block  = (eff_slot == 3'd0) || !eff_valid;

    // Controller next state; a transaction that needs no new block goes straight out when the output register is free.
    always_comb begin
        n_state = r_state;
        core_req.start = 1'b0;
        core_req.counter = eff_counter;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (need_block) begin
                        core_req.start = 1'b1;
                        n_state = ST_GEN;
                    end else if (out_free) begin
                        load_out = 1'b1;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_GEN: begin
                if (core_stat.done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result from the live or the held item.
    always_comb begin
        sel_item = (r_state == ST_IDLE) ? i_in_item : r_item;
        sel_slot = (r_state == ST_IDLE) ? eff_slot : r_item_slot;
        sel_count = sat_count(sel_item.byte_count);
        n_out.data_out = (sel_item.data_in ^ ks[sel_slot]) & byte_mask(sel_count);
        n_out.valid_bytes = sel_count;
    end

    cc20_core #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (core_req),
        .i_key  ({r_key[3], r_key[2], r_key[1], r_key[0]}),
        .i_nonce({r_nonce_high, r_nonce_low}),
        .o_stat (core_stat),
        .o_ks   (ks)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_counter   <= '0;
            r_slot      <= '0;
            r_blk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_slot      <= eff_slot + 3'd1;
                r_blk_valid <= 1'b1;
                if (need_block) r_counter <= eff_counter + 32'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item      <= i_in_item;
            r_item_slot <= eff_slot;
        end
        if (load_out) r_out <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ----- src/cc20_checker.sv -----
// Port-level assertions for the ChaCha20 stream XOR block, bound to the top level.
`default_nettype none

module cc20_checker
    import cc20_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // An offered input transaction stays in place until it is accepted.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input transaction changed while waiting");

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output transaction changed while stalled");

    // The byte count is never above eight.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.valid_bytes <= MAX_BYTES)
        else $error("valid byte count above eight");

    // Bytes past the valid count are zero.
    a_zero_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.valid_bytes < MAX_BYTES
            |-> (o_out_item.data_out >> {o_out_item.valid_bytes, 3'b000}) == 64'd0)
        else $error("nonzero byte beyond valid count");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind chacha20_stream_xor_top cc20_checker u_cc20_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_item (o_out_item)
);

`default_nettype wire

// ----- sim/chacha20_stream_xor_top_test.sv -----
// Self-checking testbench for the ChaCha20 stream XOR top level, with its own keystream predictor.
module chacha20_stream_xor_top_test;
    import cc20_pkg::*;

    localparam int N_DOUBLE        = DOUBLE_ROUNDS_DEF;
    localparam int N_REGS          = 7;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int CALM_PHASE      = 4;
    localparam int IDLE_PCT        = 16;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 2 * N_DOUBLE + 10;
    localparam int MAX_REPORTS     = 100;

    // One row of the directed stimulus table.
    typedef struct {
        bit          first;
        logic [63:0] data;
        logic [3:0]  count;
        bit          typed;
        t_out_item   want;
    } t_stim_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    // Predictor copy of the configuration and the stream state.
    logic [255:0] cipher_key   = '0;
    logic [95:0]  cipher_nonce = '0;
    t_word        start_ctr    = '0;
    t_words       ks_words     = '0;
    t_word        blk_ctr      = '0;
    logic [5:0]   byte_pos     = '0;
    bit           blk_held     = 1'b0;

    t_out_item   pending_cipher_q [$];
    t_stim_row   directed_rows [$];
    logic [63:0] reg_vals [N_REGS];

    int   mismatches    = 0;
    int   items_sent    = 0;
    int   results_seen  = 0;
    int   blocks_made   = 0;
    int   settings_done = 0;
    int   idle_pct      = IDLE_PCT;
    logic hold_off      = 1'b0;

    chacha20_stream_xor_top #(.DOUBLE_ROUNDS(N_DOUBLE)) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin : clock_gen
        forever #1 clk = ~clk;
    end

    // Left rotation of one 32-bit word.
    function automatic t_word rotate_left(input t_word x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // One quarter round on the four words of a lane.
    function automatic t_quad quarter_round(input t_quad q);
        q.a = q.a + q.b;
        q.d = rotate_left(q.d ^ q.a, 16);
        q.c = q.c + q.d;
        q.b = rotate_left(q.b ^ q.c, 12);
        q.a = q.a + q.b;
        q.d = rotate_left(q.d ^ q.a, 8);
        q.c = q.c + q.d;
        q.b = rotate_left(q.b ^ q.c, 7);
        return q;
    endfunction

    // Full 64-byte keystream block for one counter value under the current key and nonce.
    function automatic t_words keystream_block(input t_word ctr);
        t_words init;
        t_words w;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int i = 0; i < 8; i++) begin
            init[4 + i] = cipher_key[32*i +: 32];
        end
        init[12] = ctr;
        for (int i = 0; i < 3; i++) begin
            init[13 + i] = cipher_nonce[32*i +: 32];
        end
        w = init;
        for (int r = 0; r < N_DOUBLE; r++) begin
            // Column round, then diagonal round.
            {w[0], w[4], w[8],  w[12]} = quarter_round({w[0], w[4], w[8],  w[12]});
            {w[1], w[5], w[9],  w[13]} = quarter_round({w[1], w[5], w[9],  w[13]});
            {w[2], w[6], w[10], w[14]} = quarter_round({w[2], w[6], w[10], w[14]});
            {w[3], w[7], w[11], w[15]} = quarter_round({w[3], w[7], w[11], w[15]});
            {w[0], w[5], w[10], w[15]} = quarter_round({w[0], w[5], w[10], w[15]});
            {w[1], w[6], w[11], w[12]} = quarter_round({w[1], w[6], w[11], w[12]});
            {w[2], w[7], w[8],  w[13]} = quarter_round({w[2], w[7], w[8],  w[13]});
            {w[3], w[4], w[9],  w[14]} = quarter_round({w[3], w[4], w[9],  w[14]});
        end
        for (int i = 0; i < 16; i++) begin
            w[i] = w[i] + init[i];
        end
        return w;
    endfunction

    // Advances the predicted stream by one transaction and returns its ciphertext.
    function automatic t_out_item cipher_step(input t_in_item it);
        t_out_item   res;
        logic [3:0]  n;
        logic [63:0] ks;
        logic [63:0] keep;
        int          widx;
        if (it.first) begin
            blk_ctr  = start_ctr;
            byte_pos = '0;
            blk_held = 1'b0;
        end
        if (byte_pos == 0 || !blk_held) begin
            ks_words = keystream_block(blk_ctr);
            blk_ctr  = blk_ctr + 1;
            blk_held = 1'b1;
            blocks_made++;
        end
        widx = 2 * int'(byte_pos[5:3]);
        ks   = {ks_words[widx + 1], ks_words[widx]};
        n    = (it.byte_count > MAX_BYTES) ? MAX_BYTES : it.byte_count;
        keep = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < n) keep[8*b +: 8] = 8'hFF;
        end
        res.data_out    = (it.data_in ^ ks) & keep;
        res.valid_bytes = n;
        // A short item still moves the position by a full eight bytes.
        byte_pos = byte_pos + 6'd8;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
        end
    endtask

    function automatic void add_row(input bit first, input logic [63:0] data,
                                    input logic [3:0] count, input bit typed,
                                    input logic [63:0] want_data, input logic [3:0] want_bytes);
        t_stim_row row;
        row.first            = first;
        row.data             = data;
        row.count            = count;
        row.typed            = typed;
        row.want.data_out    = want_data;
        row.want.valid_bytes = want_bytes;
        directed_rows.push_back(row);
    endfunction

    // Offers one transaction, with random gaps, and records its result once accepted.
    task automatic offer(input t_in_item it, input t_out_item want);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        pending_cipher_q.push_back(want);
        items_sent++;
    endtask

    task automatic send(input bit first, input logic [63:0] data, input logic [3:0] count);
        t_in_item it;
        it.first      = first;
        it.data_in    = data;
        it.byte_count = count;
        offer(it, cipher_step(it));
    endtask

    // Mostly well-formed messages, with some free-form items in between.
    task automatic random_traffic(input int n_items);
        int left;
        int len;
        bit resume;
        left   = n_items;
        resume = 1'($urandom_range(1));
        while (left > 0) begin
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
                for (int k = 0; k < len; k++) begin
                    // The opening message may continue the stream from before the new setting.
                    send(k == 0 && !resume, {$urandom, $urandom},
                         (k == len - 1) ? 4'($urandom_range(1, 8)) : MAX_BYTES);
                end
                left -= len;
            end else begin
                send(1'($urandom_range(1)), {$urandom, $urandom}, 4'($urandom_range(15)));
                left--;
            end
            resume = 1'b0;
        end
    endtask

    // Writes every register from reg_vals and mirrors each write in the predictor.
    task automatic program_regs();
        t_cfg_idx idx;
        for (int r = 0; r < N_REGS; r++) begin
            idx = t_cfg_idx'(r);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_vals[r];
            @(posedge clk);
            case (idx)
                CFG_KEY_0:         cipher_key[63:0]     = reg_vals[r];
                CFG_KEY_1:         cipher_key[127:64]   = reg_vals[r];
                CFG_KEY_2:         cipher_key[191:128]  = reg_vals[r];
                CFG_KEY_3:         cipher_key[255:192]  = reg_vals[r];
                CFG_NONCE_LOW:     cipher_nonce[63:0]   = reg_vals[r];
                CFG_NONCE_HIGH:    cipher_nonce[95:64]  = reg_vals[r][31:0];
                CFG_START_COUNTER: start_ctr            = reg_vals[r][31:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic wait_drained();
        while (pending_cipher_q.size() != 0) @(posedge clk);
    endtask

    // Stimulus: reset, directed table, then random phases under changing settings.
    initial begin : stimulus
        t_in_item  it;
        t_out_item want;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Without a first flag the stream starts at counter zero; this block is all zero keys.
        add_row(0, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0, '0, '0);
        add_row(0, 64'h0123_4567_89AB_CDEF, 4'd8,  0, '0, '0);
        add_row(0, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  0, '0, '0);
        add_row(0, 64'h5555_5555_5555_5555, 4'd8,  0, '0, '0);
        add_row(0, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(0, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0, '0, '0);
        // Second block of the stream, still without a first flag.
        add_row(0, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1, '0, 4'd0);
        add_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 0, '0, '0);
        add_row(0, 64'h0000_0000_0000_0000, 4'd9,  0, '0, '0);
        add_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  0, '0, '0);
        add_row(0, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0, '0, '0);
        add_row(0, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        // Restarts at the start counter, including back-to-back restarts.
        add_row(1, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1, '0, 4'd0);
        add_row(1, 64'h0000_0000_0000_0000, 4'd7,  0, '0, '0);
        add_row(0, 64'h8000_0000_0000_0001, 4'd8,  0, '0, '0);
        add_row(1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  0, '0, '0);
        add_row(1, 64'h0000_0000_0000_0000, 4'd0,  1, '0, 4'd0);
        add_row(1, 64'h0000_0000_0000_0000, 4'd8,  0, '0, '0);
        add_row(1, 64'h5555_5555_5555_5555, 4'd4,  0, '0, '0);

        foreach (directed_rows[i]) begin
            it.first      = directed_rows[i].first;
            it.data_in    = directed_rows[i].data;
            it.byte_count = directed_rows[i].count;
            want = cipher_step(it);
            if (directed_rows[i].typed) want = directed_rows[i].want;
            offer(it, want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            in_valid <= 1'b0;
            wait_drained();
            idle_pct <= (p == CALM_PHASE) ? 0 : IDLE_PCT;
            for (int r = 0; r < N_REGS; r++) begin
                case (p)
                    0:       reg_vals[r] = '0;
                    1:       reg_vals[r] = '1;
                    default: reg_vals[r] = {$urandom, $urandom};
                endcase
            end
            // Some settings start just short of the counter wrap.
            if (p == 2 || p == 7) begin
                reg_vals[int'(CFG_START_COUNTER)][31:0] = 32'hFFFF_FFFE;
            end
            program_regs();
            random_traffic(ITEMS_PER_PHASE);
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transactions in and %0d results out over %0d register settings,",
                 items_sent, results_seen, settings_done);
        $display("with %0d keystream blocks, counter wrap, restarts and short or oversized counts.",
                 blocks_made);
        if (mismatches == 0) begin
            $display("chacha20_stream_xor_top_test: clean");
        end else begin
            $display("chacha20_stream_xor_top_test: errors");
        end
        $finish;
    end

    // One long receiver hold-off, counted in cycles, while the sender keeps offering.
    initial begin : receiver_hold
        wait (items_sent >= HOLD_AFTER);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Result checker and receiver backpressure.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_cipher_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result data %h bytes %0d",
                                          out_item.data_out, out_item.valid_bytes));
            end else begin
                want = pending_cipher_q.pop_front();
                if (out_item.data_out !== want.data_out) begin
                    report_mismatch($sformatf("data_out %h, predicted %h",
                                              out_item.data_out, want.data_out));
                end
                if (out_item.valid_bytes !== want.valid_bytes) begin
                    report_mismatch($sformatf("valid_bytes %0d, predicted %0d",
                                              out_item.valid_bytes, want.valid_bytes));
                end
            end
        end
        out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
    end

    initial begin : watchdog
        #600000;
        $display("chacha20_stream_xor_top_test: errors");
        $finish;
    end

endmodule
